// File: hdl/gpio_pin_controller_with_irq_detect_macros.svh
// Assertion macros used by the top-level controller RTL file.
`ifndef GPIO_PIN_CONTROLLER_WITH_IRQ_DETECT_MACROS_SVH
`define GPIO_PIN_CONTROLLER_WITH_IRQ_DETECT_MACROS_SVH

`ifndef SYNTHESIS
`define GPIOC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("GPIO controller check failed");
`define GPIOC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("GPIO controller reset check failed");
`else
`define GPIOC_ASSERT(lbl, clk, rst, prop)
`define GPIOC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: hdl/gpioc_pkg.sv
package gpioc_pkg;

  localparam int REG_WORDS = 512;
  localparam int IX_W = 9;
  localparam int SLOT_W = 4;
  localparam int IRQ_W = 5;
  localparam int DATA_W = 32;
  localparam int PBANK_W = 3;
  localparam int ADDR_W = 13;

  localparam logic [IX_W-1:0] IX_CTRL = 9'h000;
  localparam logic [IX_W-1:0] IX_DOUT = 9'h070;
  localparam logic [IX_W-1:0] IX_DIN = 9'h090;
  localparam logic [IX_W-1:0] IX_DOE = 9'h0B0;
  localparam logic [IX_W-1:0] IX_EN = 9'h100;
  localparam logic [IX_W-1:0] IX_SEL = 9'h110;
  localparam logic [IX_W-1:0] IX_LVL = 9'h120;
  localparam logic [IX_W-1:0] IX_POL = 9'h130;
  localparam logic [IX_W-1:0] IX_STAT = 9'h140;

  localparam int CTRL_SOFT_RST = 31;
  localparam int CTRL_CLK_GATE = 30;

  typedef enum logic [1:0] {
    ACT_READ,
    ACT_WRITE,
    ACT_PIN_DETECT,
    ACT_PIN_POLL
  } action_t;

  typedef enum logic [1:0] {
    AL_WRITE,
    AL_SET,
    AL_CLEAR,
    AL_TOGGLE
  } alias_t;

  typedef enum logic [3:0] {
    GRP_PLAIN,
    GRP_DOUT,
    GRP_DIN,
    GRP_DOE,
    GRP_EN,
    GRP_SEL,
    GRP_LVL,
    GRP_POL,
    GRP_STAT
  } grp_t;

  typedef struct packed {
    action_t             act;
    grp_t                grp;
    logic [SLOT_W-1:0]   slot;
    logic [PBANK_W-1:0]  pin_bank;
  } bank_cmd_t;

  function automatic grp_t grp_of_row(logic [IX_W-SLOT_W-1:0] row);
    grp_t g;
    case (row)
      IX_DOUT[IX_W-1:SLOT_W]: g = GRP_DOUT;
      IX_DIN[IX_W-1:SLOT_W]:  g = GRP_DIN;
      IX_DOE[IX_W-1:SLOT_W]:  g = GRP_DOE;
      IX_EN[IX_W-1:SLOT_W]:   g = GRP_EN;
      IX_SEL[IX_W-1:SLOT_W]:  g = GRP_SEL;
      IX_LVL[IX_W-1:SLOT_W]:  g = GRP_LVL;
      IX_POL[IX_W-1:SLOT_W]:  g = GRP_POL;
      IX_STAT[IX_W-1:SLOT_W]: g = GRP_STAT;
      default:                g = GRP_PLAIN;
    endcase
    return g;
  endfunction

endpackage

// File: hdl/gpio_pin_controller_with_irq_detect.sv
// Multi-bank GPIO controller with set, clear and toggle register aliases and per-bank
// pin interrupt detection. Each input transfer is a bus read, a bus write or a pin
// update; each yields exactly one result transfer carrying the read data, the five
// interrupt lines and the output data, output enable and external levels of the
// queried bank. One transfer is taken per clock cycle unless the output is stalled or
// the store is being cleared; it is held in the input register and then passes through
// a single stage of logic into the result register. After reset the 512-word register
// store is cleared one word per cycle, and s_tready stays low until that is done.
`include "gpio_pin_controller_with_irq_detect_macros.svh"

module gpio_pin_controller_with_irq_detect #(
  parameter int BANKS = 5
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // address [12:0], pin_bank [15:13], data_value [47:16]
  input  logic [47:0]  s_tdata,
  // action [1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // read_data [31:0], irq_lines [36:32], bank_dout [68:37], bank_doe [100:69],
  // bank_ext [132:101], outputs_changed [133], zero [135:134]
  output logic [135:0] m_tdata
);
  import gpioc_pkg::*;

  localparam int CHG_BIT = 133;

  logic                 in_valid;
  action_t              r_act;
  logic [ADDR_W-1:0]    r_addr;
  logic [PBANK_W-1:0]   r_bank;
  logic [DATA_W-1:0]    r_data;
  logic                 byp_hit;
  logic [DATA_W-1:0]    byp_data;

  logic                 accept;
  logic                 out_load;
  logic                 ram_busy;
  logic [DATA_W-1:0]    mem_rd;
  logic                 mem_we;
  logic [IX_W-1:0]      in_ix;

  logic [IX_W-1:0]      ix;
  alias_t               al;
  grp_t                 row_grp;
  grp_t                 grp;
  logic [DATA_W-1:0]    old;
  logic [DATA_W-1:0]    nv;
  logic [DATA_W-1:0]    rd;
  logic                 touched;
  bank_cmd_t            cmd;
  logic [DATA_W-1:0]    bank_rd;
  logic [IRQ_W-1:0]     irq;
  logic [DATA_W-1:0]    q_dout;
  logic [DATA_W-1:0]    q_doe;
  logic [DATA_W-1:0]    q_ext;

  assign out_load = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !ram_busy && (!in_valid || out_load);
  assign accept   = s_tvalid && s_tready;
  assign in_ix    = s_tdata[ADDR_W-1:SLOT_W];

  assign ix      = r_addr[ADDR_W-1:SLOT_W];
  assign al      = alias_t'(r_addr[3:2]);
  assign row_grp = grp_of_row(ix[IX_W-1:SLOT_W]);
  assign grp     = ((row_grp != GRP_PLAIN) && (5'(ix[SLOT_W-1:0]) < 5'(BANKS))) ?
                   row_grp : GRP_PLAIN;

  always_comb begin
    if (grp != GRP_PLAIN) begin
      old = bank_rd;
    end else if (byp_hit) begin
      old = byp_data;
    end else begin
      old = mem_rd;
    end
    case (al)
      AL_WRITE:  nv = r_data;
      AL_SET:    nv = old | r_data;
      AL_CLEAR:  nv = old & ~r_data;
      AL_TOGGLE: nv = old ^ r_data;
      default:   nv = r_data;
    endcase
    if ((ix == IX_CTRL) && nv[CTRL_SOFT_RST]) begin
      nv[CTRL_CLK_GATE] = 1'b1;
    end
  end

  assign rd      = (r_act == ACT_READ) ? old : '0;
  assign touched = (r_act == ACT_WRITE) && ((grp == GRP_DOUT) || (grp == GRP_DOE));
  assign mem_we  = out_load && (r_act == ACT_WRITE) && (grp == GRP_PLAIN);

  always_comb begin
    cmd          = '0;
    cmd.act      = r_act;
    cmd.grp      = grp;
    cmd.slot     = ix[SLOT_W-1:0];
    cmd.pin_bank = r_bank;
  end

  gpioc_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (in_ix),
    .rd_data (mem_rd),
    .wr_en   (mem_we),
    .wr_addr (ix),
    .wr_data (nv),
    .busy    (ram_busy)
  );

  gpioc_banks #(
    .BANKS (BANKS)
  ) u_banks (
    .clk        (clk),
    .rst        (rst),
    .upd        (out_load),
    .cmd        (cmd),
    .wdata      (nv),
    .pin_levels (r_data),
    .rd_val     (bank_rd),
    .irq        (irq),
    .q_dout     (q_dout),
    .q_doe      (q_doe),
    .q_ext      (q_ext)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (out_load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_act    <= action_t'(s_tuser);
      r_addr   <= s_tdata[ADDR_W-1:0];
      r_bank   <= s_tdata[ADDR_W+PBANK_W-1:ADDR_W];
      r_data   <= s_tdata[ADDR_W+PBANK_W+DATA_W-1:ADDR_W+PBANK_W];
      byp_hit  <= mem_we && (ix == in_ix);
      byp_data <= nv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {2'b00, touched, q_ext, q_doe, q_dout, irq, rd};
    end
  end

  `GPIOC_ASSERT(a_no_accept_clearing, clk, rst, ram_busy |-> !s_tready)
  `GPIOC_ASSERT(a_read_zero, clk, rst, out_load && (r_act != ACT_READ) |=> m_tdata[31:0] == 32'd0)
  `GPIOC_ASSERT(a_changed_write, clk, rst, out_load && (r_act != ACT_WRITE) |=> !m_tdata[CHG_BIT])
  `GPIOC_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !m_tvalid && !in_valid && !s_tready)

endmodule

// File: hdl/gpioc_ram.sv
module gpioc_ram (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            rd_en,
  input  logic [gpioc_pkg::IX_W-1:0]      rd_addr,
  output logic [gpioc_pkg::DATA_W-1:0]    rd_data,
  input  logic                            wr_en,
  input  logic [gpioc_pkg::IX_W-1:0]      wr_addr,
  input  logic [gpioc_pkg::DATA_W-1:0]    wr_data,
  output logic                            busy
);
  import gpioc_pkg::*;

  logic [DATA_W-1:0] mem [REG_WORDS];
  logic [IX_W:0]     clr_cnt;
  logic              we;
  logic [IX_W-1:0]   wa;
  logic [DATA_W-1:0] wd;

  assign busy = !clr_cnt[IX_W];

  always_comb begin
    if (busy) begin
      we = 1'b1;
      wa = clr_cnt[IX_W-1:0];
      wd = '0;
    end else begin
      we = wr_en;
      wa = wr_addr;
      wd = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/gpioc_banks.sv
module gpioc_banks #(
  parameter int BANKS = 5
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           upd,
  input  gpioc_pkg::bank_cmd_t           cmd,
  input  logic [gpioc_pkg::DATA_W-1:0]   wdata,
  input  logic [gpioc_pkg::DATA_W-1:0]   pin_levels,
  output logic [gpioc_pkg::DATA_W-1:0]   rd_val,
  output logic [gpioc_pkg::IRQ_W-1:0]    irq,
  output logic [gpioc_pkg::DATA_W-1:0]   q_dout,
  output logic [gpioc_pkg::DATA_W-1:0]   q_doe,
  output logic [gpioc_pkg::DATA_W-1:0]   q_ext
);
  import gpioc_pkg::*;

  localparam int BW = (BANKS > 1) ? $clog2(BANKS) : 1;

  logic [DATA_W-1:0] dout [BANKS];
  logic [DATA_W-1:0] doe [BANKS];
  logic [DATA_W-1:0] en [BANKS];
  logic [DATA_W-1:0] sel [BANKS];
  logic [DATA_W-1:0] lvl [BANKS];
  logic [DATA_W-1:0] pol [BANKS];
  logic [DATA_W-1:0] stat [BANKS];
  logic [DATA_W-1:0] ext [BANKS];

  logic [DATA_W-1:0] dout_next [BANKS];
  logic [DATA_W-1:0] doe_next [BANKS];
  logic [DATA_W-1:0] en_next [BANKS];
  logic [DATA_W-1:0] sel_next [BANKS];
  logic [DATA_W-1:0] lvl_next [BANKS];
  logic [DATA_W-1:0] pol_next [BANKS];
  logic [DATA_W-1:0] stat_next [BANKS];
  logic [DATA_W-1:0] ext_next [BANKS];

  logic [BW-1:0] sidx;
  logic [BW-1:0] pidx;
  logic          pin_ok;
  logic          pin_act;

  assign sidx    = cmd.slot[BW-1:0];
  assign pidx    = BW'(cmd.pin_bank);
  assign pin_ok  = 5'(cmd.pin_bank) < 5'(BANKS);
  assign pin_act = (cmd.act == ACT_PIN_DETECT) || (cmd.act == ACT_PIN_POLL);

  always_comb begin
    case (cmd.grp)
      GRP_DOUT: rd_val = dout[sidx];
      GRP_DIN:  rd_val = (dout[sidx] & doe[sidx]) | (ext[sidx] & ~doe[sidx]);
      GRP_DOE:  rd_val = doe[sidx];
      GRP_EN:   rd_val = en[sidx];
      GRP_SEL:  rd_val = sel[sidx];
      GRP_LVL:  rd_val = lvl[sidx];
      GRP_POL:  rd_val = pol[sidx];
      GRP_STAT: rd_val = stat[sidx];
      default:  rd_val = '0;
    endcase
  end

  always_comb begin
    logic [DATA_W-1:0] prior;
    logic [DATA_W-1:0] after;
    logic [DATA_W-1:0] inputs;
    logic [DATA_W-1:0] changed;
    logic [DATA_W-1:0] dir;
    logic [DATA_W-1:0] st;
    logic [DATA_W-1:0] lsi;

    for (int b = 0; b < BANKS; b++) begin
      dout_next[b] = dout[b];
      doe_next[b]  = doe[b];
      en_next[b]   = en[b];
      sel_next[b]  = sel[b];
      lvl_next[b]  = lvl[b];
      pol_next[b]  = pol[b];
      stat_next[b] = stat[b];
      ext_next[b]  = ext[b];
    end

    if (cmd.act == ACT_WRITE) begin
      case (cmd.grp)
        GRP_DOUT: dout_next[sidx] = wdata;
        GRP_DOE:  doe_next[sidx]  = wdata;
        GRP_EN:   en_next[sidx]   = wdata;
        GRP_SEL:  sel_next[sidx]  = wdata;
        GRP_LVL:  lvl_next[sidx]  = wdata;
        GRP_POL:  pol_next[sidx]  = wdata;
        GRP_STAT: stat_next[sidx] = wdata;
        default:  ;
      endcase
    end

    prior   = (dout[pidx] & doe[pidx]) | (ext[pidx] & ~doe[pidx]);
    after   = (dout[pidx] & doe[pidx]) | (pin_levels & ~doe[pidx]);
    inputs  = ~doe[pidx];
    changed = (prior ^ after) & inputs;
    dir     = (after & pol[pidx]) | (~after & ~pol[pidx]);
    lsi     = lvl[pidx] & sel[pidx] & inputs;
    st      = stat[pidx] | (changed & ~lvl[pidx] & sel[pidx] & dir);
    st      = (st & ~lsi) | (dir & lsi);

    if (pin_act && pin_ok) begin
      ext_next[pidx] = pin_levels;
      if ((cmd.act == ACT_PIN_DETECT) && (changed != '0)) begin
        stat_next[pidx] = st;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < BANKS; b++) begin
        dout[b] <= '0;
        doe[b]  <= '0;
        en[b]   <= '0;
        sel[b]  <= '0;
        lvl[b]  <= '0;
        pol[b]  <= '0;
        stat[b] <= '0;
        ext[b]  <= '1;
      end
    end else if (upd) begin
      for (int b = 0; b < BANKS; b++) begin
        dout[b] <= dout_next[b];
        doe[b]  <= doe_next[b];
        en[b]   <= en_next[b];
        sel[b]  <= sel_next[b];
        lvl[b]  <= lvl_next[b];
        pol[b]  <= pol_next[b];
        stat[b] <= stat_next[b];
        ext[b]  <= ext_next[b];
      end
    end
  end

  for (genvar g = 0; g < IRQ_W; g++) begin : g_irq
    if (g < BANKS) begin : g_line
      assign irq[g] = |(stat_next[g] & en_next[g] & sel_next[g]);
    end else begin : g_none
      assign irq[g] = 1'b0;
    end
  end

  assign q_dout = pin_ok ? dout_next[pidx] : '0;
  assign q_doe  = pin_ok ? doe_next[pidx] : '0;
  assign q_ext  = pin_ok ? ext_next[pidx] : '0;

endmodule
